[rtl/core/txb_pkg.sv]
// Shared constants and types for the timestamped XOR basis insert block.
package txb_pkg;

  localparam int WIDTH_DEF      = 64;
  localparam int STAMP_BITS_DEF = 20;
  localparam int ROW_BITS       = 6;

  localparam logic OUTCOME_FILLED  = 1'b0;
  localparam logic OUTCOME_DROPPED = 1'b1;

  typedef struct packed {
    logic valid;
    logic done;
  } txb_ctl_t;

endpackage

[rtl/core/txb_if.sv]
// Request and result channel interfaces for the timestamped XOR basis insert block.
interface txb_in_if #(
  parameter int WIDTH      = txb_pkg::WIDTH_DEF,
  parameter int STAMP_BITS = txb_pkg::STAMP_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [WIDTH-1:0]      vector_bits;
  logic [STAMP_BITS-1:0] stamp;

  modport source (output valid, output vector_bits, output stamp, input ready);
  modport sink   (input valid, input vector_bits, input stamp, output ready);
endinterface

interface txb_out_if #(
  parameter int STAMP_BITS = txb_pkg::STAMP_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            outcome;
  logic [txb_pkg::ROW_BITS-1:0]    row_index;
  logic [STAMP_BITS-1:0]           dropped_stamp;

  modport source (output valid, output outcome, output row_index, output dropped_stamp,
                  input ready);
  modport sink   (input valid, input outcome, input row_index, input dropped_stamp,
                  output ready);
endinterface

[rtl/core/txb_cell.sv]
// One pivot cell: holds one basis row with its stamp and reduces the passing candidate.
module txb_cell import txb_pkg::*; #(
  parameter int WIDTH      = WIDTH_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  txb_ctl_t              ctl_i,
  input  logic [WIDTH-1:0]      vec_i,
  input  logic [STAMP_BITS-1:0] stamp_i,
  input  logic [ROW_BITS-1:0]   row_i,
  output txb_ctl_t              ctl_o,
  output logic [WIDTH-1:0]      vec_o,
  output logic [STAMP_BITS-1:0] stamp_o,
  output logic [ROW_BITS-1:0]   row_o
);

  txb_ctl_t              ctl_q, ctl_d;
  logic [WIDTH-1:0]      vec_q, vec_d;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;
  logic [ROW_BITS-1:0]   row_q, row_d;

  logic [WIDTH-1:0]      basis_q;
  logic [STAMP_BITS-1:0] basis_stamp_q;
  logic                  basis_valid_q;

  logic hit, fill, swap;

  always_comb begin
    hit  = ctl_i.valid && !ctl_i.done && vec_i[INDEX];
    fill = hit && !basis_valid_q;
    swap = hit && basis_valid_q && (basis_stamp_q < stamp_i);

    ctl_d      = ctl_i;
    ctl_d.done = ctl_i.done || fill;
    // A swap followed by the XOR leaves the same candidate as the XOR alone.
    vec_d   = (hit && basis_valid_q) ? (vec_i ^ basis_q) : vec_i;
    stamp_d = swap ? basis_stamp_q : stamp_i;
    row_d   = fill ? ROW_BITS'(INDEX) : row_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q         <= '0;
      basis_valid_q <= 1'b0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
      if (fill) begin
        basis_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q   <= vec_d;
      stamp_q <= stamp_d;
      row_q   <= row_d;
      if (fill || swap) begin
        basis_q       <= vec_i;
        basis_stamp_q <= stamp_i;
      end
    end
  end

  assign ctl_o   = ctl_q;
  assign vec_o   = vec_q;
  assign stamp_o = stamp_q;
  assign row_o   = row_q;

endmodule

[rtl/core/timestamped_xor_basis_insert_core.sv]
// Top level of the timestamped GF(2) basis insert block: a systolic row of pivot cells.
//
//   channel   direction   payload
//   in_i      request     vector_bits[WIDTH], stamp[STAMP_BITS]
//   out_o     result      outcome, row_index[6], dropped_stamp[STAMP_BITS]
//
// Each request passes through WIDTH pivot cells, each registering it in turn; one
// request is taken every cycle while the result side is not stalled.
// Reset empties every basis row and the whole pipeline at once.
// A stalled result holds the entire row of cells, and in_i.ready drops with it.
module timestamped_xor_basis_insert_core import txb_pkg::*; #(
  parameter int WIDTH      = WIDTH_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  txb_in_if.sink    in_i,
  txb_out_if.source out_o
);

  txb_ctl_t              ctl   [WIDTH+1];
  logic [WIDTH-1:0]      vec   [WIDTH+1];
  logic [STAMP_BITS-1:0] stamp [WIDTH+1];
  logic [ROW_BITS-1:0]   row   [WIDTH+1];
  logic                  advance;

  assign advance = !ctl[WIDTH].valid || out_o.ready;

  assign in_i.ready   = advance;
  assign ctl[0]       = '{valid: in_i.valid, done: 1'b0};
  assign vec[0]       = in_i.vector_bits;
  assign stamp[0]     = in_i.stamp;
  assign row[0]       = '0;

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    txb_cell #(
      .WIDTH      (WIDTH),
      .STAMP_BITS (STAMP_BITS),
      .INDEX      (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .ctl_i   (ctl[k]),
      .vec_i   (vec[k]),
      .stamp_i (stamp[k]),
      .row_i   (row[k]),
      .ctl_o   (ctl[k+1]),
      .vec_o   (vec[k+1]),
      .stamp_o (stamp[k+1]),
      .row_o   (row[k+1])
    );
  end

  assign out_o.valid         = ctl[WIDTH].valid;
  assign out_o.outcome       = ctl[WIDTH].done ? OUTCOME_FILLED : OUTCOME_DROPPED;
  assign out_o.row_index     = ctl[WIDTH].done ? row[WIDTH] : '0;
  assign out_o.dropped_stamp = ctl[WIDTH].done ? '0 : stamp[WIDTH];

endmodule

[rtl/core/txb_checker.sv]
// Port-level checks for the timestamped XOR basis insert block, bound to the top level.
module txb_checker import txb_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  outcome_i,
  input logic [ROW_BITS-1:0]   row_index_i,
  input logic [STAMP_BITS-1:0] dropped_stamp_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result was withdrawn while stalled.");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("Request ready does not follow the result side.");

  a_dropped_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && outcome_i == OUTCOME_DROPPED |-> row_index_i == '0)
    else $error("Dropped result carries a row index.");

  a_filled_stamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && outcome_i == OUTCOME_FILLED |-> dropped_stamp_i == '0)
    else $error("Filled result carries a dropped stamp.");

endmodule

bind timestamped_xor_basis_insert_core txb_checker #(
  .STAMP_BITS (STAMP_BITS)
) u_txb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .outcome_i       (out_o.outcome),
  .row_index_i     (out_o.row_index),
  .dropped_stamp_i (out_o.dropped_stamp)
);

[bench/timestamped_xor_basis_insert_core_tb.sv]
// Self-checking testbench for the timestamped GF(2) basis insert core.
module timestamped_xor_basis_insert_core_tb import txb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VEC_BITS       = WIDTH_DEF;
  localparam int STAMP_W        = STAMP_BITS_DEF;
  localparam int PIPE_DEPTH     = VEC_BITS;
  localparam int PHASE_REQUESTS = 650;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic                outcome;
    logic [ROW_BITS-1:0] row_index;
    logic [STAMP_W-1:0]  dropped_stamp;
  } basis_result_t;

  typedef struct packed {
    logic [VEC_BITS-1:0] vec;
    logic [STAMP_W-1:0]  stamp;
    logic                typed;
    basis_result_t       res;
  } basis_stim_t;

  localparam basis_result_t NO_RESULT = '0;
  localparam int NUM_DIRECTED = 18;
  localparam basis_stim_t DIRECTED_STIM [NUM_DIRECTED] = '{
    '{64'h0, 20'h12345, 1'b1, '{OUTCOME_DROPPED, 6'd0, 20'h12345}},
    '{64'h0, 20'hFFFFF, 1'b1, '{OUTCOME_DROPPED, 6'd0, 20'hFFFFF}},
    '{64'h1, 20'h00005, 1'b1, '{OUTCOME_FILLED, 6'd0, 20'h0}},
    '{64'h8000_0000_0000_0000, 20'hFFFFF, 1'b1, '{OUTCOME_FILLED, 6'd63, 20'h0}},
    '{64'h1, 20'h00005, 1'b1, '{OUTCOME_DROPPED, 6'd0, 20'h00005}},
    '{64'h1, 20'h00007, 1'b0, NO_RESULT},
    '{64'h8000_0000_0000_0000, 20'h00000, 1'b1, '{OUTCOME_DROPPED, 6'd0, 20'h0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 20'h00000, 1'b0, NO_RESULT},
    '{64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF, 1'b0, NO_RESULT},
    '{64'hAAAA_AAAA_AAAA_AAAA, 20'h00003, 1'b0, NO_RESULT},
    '{64'h5555_5555_5555_5555, 20'h00003, 1'b0, NO_RESULT},
    '{64'h2, 20'h00000, 1'b0, NO_RESULT},
    '{64'h3, 20'h00008, 1'b0, NO_RESULT},
    '{64'hFFFF_FFFF_0000_0000, 20'h80000, 1'b0, NO_RESULT},
    '{64'h0000_0000_FFFF_FFFF, 20'h7FFFF, 1'b0, NO_RESULT},
    '{64'hC000_0000_0000_0000, 20'h00001, 1'b0, NO_RESULT},
    '{64'h4000_0000_0000_0000, 20'h00002, 1'b0, NO_RESULT},
    '{64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF, 1'b0, NO_RESULT}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  txb_in_if #(.WIDTH(VEC_BITS), .STAMP_BITS(STAMP_W)) in_if ();
  txb_out_if #(.STAMP_BITS(STAMP_W)) out_if ();

  timestamped_xor_basis_insert_core #(
    .WIDTH(VEC_BITS),
    .STAMP_BITS(STAMP_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #2 clk_i = ~clk_i;

  logic [VEC_BITS-1:0] basis_vec [VEC_BITS];
  logic [STAMP_W-1:0]  basis_stamp [VEC_BITS];
  bit                  basis_used [VEC_BITS];
  basis_result_t       expected_results [$];
  basis_result_t       oldest_result;
  int                  error_count = 0;
  int                  cycle_count = 0;
  int                  send_idle_pct = 31;
  int                  recv_idle_pct = 80;
  bit                  pressure_go = 1'b0;
  logic                recv_hold = 1'b0;
  logic [STAMP_W-1:0]  stamp_clock = '0;

  function automatic basis_result_t insert_vector(logic [VEC_BITS-1:0] vec,
                                                  logic [STAMP_W-1:0] stamp);
    basis_result_t       res;
    logic [VEC_BITS-1:0] cand;
    logic [VEC_BITS-1:0] swap_vec;
    logic [STAMP_W-1:0]  cand_stamp;
    logic [STAMP_W-1:0]  swap_stamp;
    cand = vec;
    cand_stamp = stamp;
    for (int k = 0; k < VEC_BITS; k++) begin
      if (cand[k]) begin
        if (!basis_used[k]) begin
          basis_vec[k] = cand;
          basis_stamp[k] = cand_stamp;
          basis_used[k] = 1'b1;
          res.outcome = OUTCOME_FILLED;
          res.row_index = ROW_BITS'(k);
          res.dropped_stamp = '0;
          return res;
        end
        if (basis_stamp[k] < cand_stamp) begin
          swap_vec = basis_vec[k];
          swap_stamp = basis_stamp[k];
          basis_vec[k] = cand;
          basis_stamp[k] = cand_stamp;
          cand = swap_vec;
          cand_stamp = swap_stamp;
        end
        cand = cand ^ basis_vec[k];
      end
    end
    res.outcome = OUTCOME_DROPPED;
    res.row_index = '0;
    res.dropped_stamp = cand_stamp;
    return res;
  endfunction

  function automatic logic [VEC_BITS-1:0] random_vector();
    logic [VEC_BITS-1:0] full;
    logic [VEC_BITS-1:0] v;
    int                  span;
    int                  shift;
    full = {$urandom, $urandom};
    span = $urandom_range(12, 1);
    shift = $urandom_range(VEC_BITS - 1);
    case ($urandom_range(9))
      0: v = '0;
      1, 2: v = full;
      3, 4, 5, 6: v = (full & ((64'h1 << span) - 64'h1)) << shift;
      7: v = 64'h1 << shift;
      8: v = full & 64'hFFFF;
      default: v = full << shift;
    endcase
    return v;
  endfunction

  function automatic logic [STAMP_W-1:0] random_stamp();
    logic [STAMP_W-1:0] s;
    case ($urandom_range(3))
      0: s = STAMP_W'($urandom_range(15));
      1: s = STAMP_W'($urandom);
      2: begin
        stamp_clock = stamp_clock + STAMP_W'($urandom_range(3));
        s = stamp_clock;
      end
      default: s = $urandom_range(1) ? '1 - STAMP_W'($urandom_range(3)) : '0;
    endcase
    return s;
  endfunction

  task automatic send_request(input logic [VEC_BITS-1:0] vec, input logic [STAMP_W-1:0] stamp,
                              input logic typed, input basis_result_t typed_res);
    basis_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.vector_bits <= vec;
    in_if.stamp <= stamp;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = insert_vector(vec, stamp);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic send_random_phase(input int count);
    repeat (count) send_request(random_vector(), random_stamp(), 1'b0, NO_RESULT);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result outcome=%0b row=%0d stamp=%h", $time,
                 out_if.outcome, out_if.row_index, out_if.dropped_stamp);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_if.outcome !== oldest_result.outcome ||
            out_if.row_index !== oldest_result.row_index ||
            out_if.dropped_stamp !== oldest_result.dropped_stamp) begin
          $display("%0t: expected outcome=%0b row=%0d stamp=%h, got outcome=%0b row=%0d stamp=%h",
                   $time, oldest_result.outcome, oldest_result.row_index,
                   oldest_result.dropped_stamp, out_if.outcome, out_if.row_index,
                   out_if.dropped_stamp);
          error_count++;
        end
      end
    end
    out_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (pressure_go);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    recv_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.vector_bits = '0;
    in_if.stamp = '0;
    out_if.ready = 1'b0;
    for (int k = 0; k < VEC_BITS; k++) begin
      basis_vec[k] = '0;
      basis_stamp[k] = '0;
      basis_used[k] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(DIRECTED_STIM[i].vec, DIRECTED_STIM[i].stamp, DIRECTED_STIM[i].typed,
                   DIRECTED_STIM[i].res);
    end
    send_random_phase(PHASE_REQUESTS);

    send_idle_pct = 80;
    recv_idle_pct = 31;
    send_random_phase(PHASE_REQUESTS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_go = 1'b1;
    send_random_phase(PHASE_REQUESTS);
    in_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 16) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
